// ===== rtl/core/barometric_pressure_compensation_assert.svh =====
// Assertion macros used by the checker file
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_ASSERT_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_ASSERT_SVH

// Check a property while out of reset
`define BPC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bpc assertion failed");

// Check a property at every edge, reset included
`define BPC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("bpc assertion failed");

`endif

// ===== rtl/core/bpc_pkg.sv =====
package bpc_pkg;

  localparam int unsigned DataW      = 32;
  localparam int unsigned CalW       = 16;
  localparam int unsigned UpW        = 19;
  localparam int unsigned OssW       = 2;
  localparam int unsigned CalIdxW    = 3;
  localparam int unsigned QueueDepth = 4;

  localparam logic [DataW-1:0] B6Offset = 32'd4000;
  localparam logic [DataW-1:0] B4Bias   = 32'd32768;
  localparam logic [15:0]      B7Scale  = 16'd50000;
  localparam logic [DataW-1:0] PCoefA   = 32'd3038;
  localparam logic [DataW-1:0] PCoefB   = 32'd7357;
  localparam logic [DataW-1:0] PCoefC   = 32'd3791;

  typedef enum logic [CalIdxW-1:0] {
    CAL_AC1   = 3'd0,
    CAL_AC2   = 3'd1,
    CAL_AC3   = 3'd2,
    CAL_AC4   = 3'd3,
    CAL_AC5   = 3'd4,
    CAL_AC6   = 3'd5,
    CAL_B1_B2 = 3'd6,
    CAL_MC_MD = 3'd7
  } cal_idx_e;

  typedef struct packed {
    logic [CalW-1:0] ac1;
    logic [CalW-1:0] ac2;
    logic [CalW-1:0] ac3;
    logic [CalW-1:0] ac4;
    logic [CalW-1:0] ac5;
    logic [CalW-1:0] ac6;
    logic [CalW-1:0] b1;
    logic [CalW-1:0] b2;
    logic [CalW-1:0] mc;
    logic [CalW-1:0] md;
  } cal_t;

  typedef struct packed {
    logic [DataW-1:0] x1;
    logic [DataW-1:0] div;
    logic [UpW-1:0]   up;
    logic [OssW-1:0]  oss;
  } fe_item_t;

  function automatic logic [DataW-1:0] asr(input logic [DataW-1:0] v, input int unsigned sh);
    return DataW'($signed(v) >>> sh);
  endfunction

  function automatic logic [DataW-1:0] sx(input logic [CalW-1:0] v);
    return {{(DataW-CalW){v[CalW-1]}}, v};
  endfunction

endpackage

// ===== rtl/core/bpc_front.sv =====
module bpc_front import bpc_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cal_t           cal_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [15:0]    raw_temperature_i,
  input  logic [UpW-1:0] raw_pressure_i,
  input  logic [OssW-1:0] oversampling_i,
  output logic           push_o,
  output fe_item_t       item_o,
  input  logic           full_i
);

  logic             v1_q, v2_q;
  logic [15:0]      ut_q;
  logic [UpW-1:0]   up1_q, up2_q;
  logic [OssW-1:0]  oss1_q, oss2_q;
  logic [DataW-1:0] prod_q, prod_d;
  logic             adv1, adv2;

  assign push_o     = v2_q && !full_i;
  assign adv2       = !v2_q || push_o;
  assign adv1       = !v1_q || adv2;
  assign in_ready_o = adv1;

  assign prod_d = ({16'b0, ut_q} - {16'b0, cal_i.ac6}) * {16'b0, cal_i.ac5};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      ut_q   <= raw_temperature_i;
      up1_q  <= raw_pressure_i;
      oss1_q <= oversampling_i;
    end
    if (adv2 && v1_q) begin
      prod_q <= prod_d;
      up2_q  <= up1_q;
      oss2_q <= oss1_q;
    end
  end

  always_comb begin
    item_o.x1  = asr(prod_q, 15);
    item_o.div = item_o.x1 + sx(cal_i.md);
    item_o.up  = up2_q;
    item_o.oss = oss2_q;
  end

endmodule

// ===== rtl/core/bpc_queue.sv =====
module bpc_queue import bpc_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  fe_item_t item_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output fe_item_t item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  fe_item_t        mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop_i)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

endmodule

// ===== rtl/core/bpc_div.sv =====
module bpc_div import bpc_pkg::*; #(
  parameter type side_t = logic
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [DataW-1:0] num_i,
  input  logic [DataW-1:0] den_i,
  input  side_t            side_i,
  output logic             valid_o,
  output logic [DataW-1:0] quo_o,
  output side_t            side_o
);

  logic             vld_q  [DataW];
  logic [DataW-1:0] rem_q  [DataW];
  logic [DataW-1:0] num_q  [DataW];
  logic [DataW-1:0] den_q  [DataW];
  side_t            side_q [DataW];

  for (genvar s = 0; s < DataW; s++) begin : g_stage
    logic             vld_in;
    logic [DataW-1:0] rem_in, num_in, den_in;
    side_t            side_in;
    logic [DataW:0]   trial, diff;
    logic             ge;

    if (s == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign num_in  = num_i;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign num_in  = num_q[s-1];
      assign den_in  = den_q[s-1];
      assign side_in = side_q[s-1];
    end

    assign trial = {rem_in, num_in[DataW-1]};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? diff[DataW-1:0] : trial[DataW-1:0];
        num_q[s]  <= {num_in[DataW-2:0], ge};
        den_q[s]  <= den_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[DataW-1];
  assign quo_o   = num_q[DataW-1];
  assign side_o  = side_q[DataW-1];

endmodule

// ===== rtl/core/bpc_back.sv =====
module bpc_back import bpc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cal_t              cal_i,
  input  logic              q_valid_i,
  input  fe_item_t          q_item_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic signed [15:0] temperature_decidegrees_o,
  output logic signed [DataW-1:0] pressure_pascal_o,
  output logic              divide_error_o
);

  typedef struct packed {
    logic             err;
    logic             neg;
    logic             hi;
    logic [UpW-1:0]   up;
    logic [OssW-1:0]  oss;
    logic [DataW-1:0] x1;
    logic [DataW-1:0] b5;
    logic [DataW-1:0] b6;
    logic [DataW-1:0] m0;
    logic [DataW-1:0] m1;
    logic [DataW-1:0] m2;
    logic [DataW-1:0] xa;
    logic [DataW-1:0] xc;
    logic [DataW-1:0] b3;
    logic [DataW-1:0] t;
    logic [DataW-1:0] diff;
    logic [DataW-1:0] b4;
    logic [DataW-1:0] b7;
    logic [DataW-1:0] p;
  } be_t;

  logic             adv;
  logic             da_vld, db_vld;
  logic [DataW-1:0] da_num, da_den, da_quo, db_num, db_den, db_quo;
  be_t              da_side, da_out, db_side, db_out;
  be_t              s1_d, s2_d, s3_d, s4_d, s5_d, s6_d, s7_d, s8_d;
  be_t              s1_q, s2_q, s3_q, s4_q, s5_q, s6_q, s7_q, s8_q;
  logic             v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q;
  logic             ov_q;
  logic signed [15:0]       temp_q, temp_d;
  logic signed [DataW-1:0]  pres_q, pres_d;
  logic             err_q;
  logic [DataW-1:0] num_s, div_abs, x3a, x3b, pa, fx1, fp, b5r;
  logic             dz, b4z;

  assign adv   = !ov_q || out_ready_i;
  assign pop_o = adv && q_valid_i;

  always_comb begin
    num_s   = {{(DataW-CalW-11){cal_i.mc[CalW-1]}}, cal_i.mc, 11'b0};
    dz      = (q_item_i.div == '0);
    div_abs = q_item_i.div[DataW-1] ? -q_item_i.div : q_item_i.div;
    da_num  = num_s[DataW-1] ? -num_s : num_s;
    da_den  = dz ? DataW'(1) : div_abs;
    da_side     = '0;
    da_side.err = dz;
    da_side.neg = num_s[DataW-1] ^ q_item_i.div[DataW-1];
    da_side.x1  = q_item_i.x1;
    da_side.up  = q_item_i.up;
    da_side.oss = q_item_i.oss;
  end

  bpc_div #(.side_t(be_t)) u_div_t (
    .clk_i, .rst_ni, .en_i(adv),
    .valid_i(pop_o), .num_i(da_num), .den_i(da_den), .side_i(da_side),
    .valid_o(da_vld), .quo_o(da_quo), .side_o(da_out)
  );

  always_comb begin
    s1_d    = da_out;
    s1_d.b5 = da_out.x1 + (da_out.neg ? -da_quo : da_quo);
    s1_d.b6 = s1_d.b5 - B6Offset;

    s2_d    = s1_q;
    s2_d.m0 = s1_q.b6 * s1_q.b6;
    s2_d.m1 = sx(cal_i.ac2) * s1_q.b6;
    s2_d.m2 = sx(cal_i.ac3) * s1_q.b6;

    s3_d    = s2_q;
    s3_d.m0 = sx(cal_i.b2) * asr(s2_q.m0, 12);
    s3_d.m1 = sx(cal_i.b1) * asr(s2_q.m0, 12);
    s3_d.xa = asr(s2_q.m1, 11);
    s3_d.xc = asr(s2_q.m2, 13);

    s4_d    = s3_q;
    x3a     = asr(s3_q.m0, 11) + s3_q.xa;
    s4_d.b3 = asr((((sx(cal_i.ac1) << 2) + x3a) << s3_q.oss) + DataW'(2), 2);
    x3b     = asr(s3_q.xc + asr(s3_q.m1, 16) + DataW'(2), 2);
    s4_d.t  = x3b + B4Bias;

    s5_d      = s4_q;
    s5_d.m0   = {16'b0, cal_i.ac4} * s4_q.t;
    s5_d.diff = {{(DataW-UpW){1'b0}}, s4_q.up} - s4_q.b3;

    s6_d     = s5_q;
    s6_d.b4  = s5_q.m0 >> 15;
    b4z      = (s6_d.b4 == '0);
    s6_d.err = s5_q.err || b4z;
    s6_d.b7  = s5_q.diff * {16'b0, B7Scale >> s5_q.oss};

    db_side    = s6_q;
    db_side.hi = s6_q.b7[DataW-1];
    db_num     = s6_q.b7[DataW-1] ? s6_q.b7 : (s6_q.b7 << 1);
    db_den     = (s6_q.b4 == '0) ? DataW'(1) : s6_q.b4;

    s7_d    = db_out;
    pa      = db_out.hi ? (db_quo << 1) : db_quo;
    s7_d.p  = pa;
    s7_d.m0 = asr(pa, 8) * asr(pa, 8);
    s7_d.m1 = PCoefB * pa;

    s8_d    = s7_q;
    s8_d.m0 = s7_q.m0 * PCoefA;
    s8_d.xa = asr(DataW'(0) - s7_q.m1, 16);

    fx1    = asr(s8_q.m0, 16);
    fp     = s8_q.p + asr(fx1 + s8_q.xa + PCoefC, 4);
    b5r    = asr(s8_q.b5 + DataW'(8), 4);
    temp_d = s8_q.err ? '0 : b5r[15:0];
    pres_d = s8_q.err ? '0 : fp;
  end

  bpc_div #(.side_t(be_t)) u_div_p (
    .clk_i, .rst_ni, .en_i(adv),
    .valid_i(v6_q), .num_i(db_num), .den_i(db_den), .side_i(db_side),
    .valid_o(db_vld), .quo_o(db_quo), .side_o(db_out)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0; v8_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (adv) begin
      v1_q <= da_vld; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;
      v5_q <= v4_q;   v6_q <= v5_q; v7_q <= db_vld; v8_q <= v7_q;
      ov_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d; s2_q <= s2_d; s3_q <= s3_d; s4_q <= s4_d;
      s5_q <= s5_d; s6_q <= s6_d; s7_q <= s7_d; s8_q <= s8_d;
      temp_q <= temp_d;
      pres_q <= pres_d;
      err_q  <= s8_q.err;
    end
  end

  assign out_valid_o               = ov_q;
  assign temperature_decidegrees_o = temp_q;
  assign pressure_pascal_o         = pres_q;
  assign divide_error_o            = err_q;

endmodule

// ===== rtl/core/barometric_pressure_compensation.sv =====
// Throughput: one request per cycle unless the output stalls; two pipelined restoring
// dividers, one quotient bit per stage, and a four-entry queue between the front and
// back pipelines.
// Reset: asynchronous, active low; clears all valid flags, queue pointers and the
// calibration registers. Calibration writes take effect on the next cycle.
module barometric_pressure_compensation import bpc_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CalIdxW-1:0]      cfg_idx_i,
  input  logic [DataW-1:0]        cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [15:0]             raw_temperature_i,
  input  logic [UpW-1:0]          raw_pressure_i,
  input  logic [OssW-1:0]         oversampling_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [15:0]      temperature_decidegrees_o,
  output logic signed [DataW-1:0] pressure_pascal_o,
  output logic                    divide_error_o
);

  cal_t     cal_q;
  fe_item_t fe_item, q_item;
  logic     push, full, pop, q_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cal_idx_e'(cfg_idx_i))
        CAL_AC1:   cal_q.ac1 <= cfg_wdata_i[CalW-1:0];
        CAL_AC2:   cal_q.ac2 <= cfg_wdata_i[CalW-1:0];
        CAL_AC3:   cal_q.ac3 <= cfg_wdata_i[CalW-1:0];
        CAL_AC4:   cal_q.ac4 <= cfg_wdata_i[CalW-1:0];
        CAL_AC5:   cal_q.ac5 <= cfg_wdata_i[CalW-1:0];
        CAL_AC6:   cal_q.ac6 <= cfg_wdata_i[CalW-1:0];
        CAL_B1_B2: begin
          cal_q.b1 <= cfg_wdata_i[DataW-1:CalW];
          cal_q.b2 <= cfg_wdata_i[CalW-1:0];
        end
        CAL_MC_MD: begin
          cal_q.mc <= cfg_wdata_i[DataW-1:CalW];
          cal_q.md <= cfg_wdata_i[CalW-1:0];
        end
        default: ;
      endcase
    end
  end

  bpc_front u_front (
    .clk_i, .rst_ni, .cal_i(cal_q),
    .in_valid_i, .in_ready_o,
    .raw_temperature_i, .raw_pressure_i, .oversampling_i,
    .push_o(push), .item_o(fe_item), .full_i(full)
  );

  bpc_queue #(.Depth(QDepth)) u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .item_i(fe_item), .full_o(full),
    .pop_i(pop), .valid_o(q_valid), .item_o(q_item)
  );

  bpc_back u_back (
    .clk_i, .rst_ni, .cal_i(cal_q),
    .q_valid_i(q_valid), .q_item_i(q_item), .pop_o(pop),
    .out_valid_o, .out_ready_i,
    .temperature_decidegrees_o, .pressure_pascal_o, .divide_error_o
  );

endmodule

// ===== rtl/core/bpc_checker.sv =====
`include "barometric_pressure_compensation_assert.svh"

module bpc_checker import bpc_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic signed [15:0]      temperature_decidegrees_o,
  input logic signed [DataW-1:0] pressure_pascal_o,
  input logic                    divide_error_o
);

  `BPC_ASSERT(a_out_hold, clk_i, rst_ni,
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pressure_pascal_o) &&
    $stable(temperature_decidegrees_o))
  `BPC_ASSERT(a_err_zero, clk_i, rst_ni,
    out_valid_o && divide_error_o |->
    temperature_decidegrees_o == 16'sd0 && pressure_pascal_o == 32'sd0)
  `BPC_ASSERT(a_idle_ready, clk_i, rst_ni,
    !$past(in_valid_i) && !$past(out_valid_o) && !out_valid_o |->
    in_ready_o || !in_ready_o && $past(!in_ready_o))
  `BPC_ASSERT_ALWAYS(a_rst_clear, clk_i, !rst_ni |=> !out_valid_o)

endmodule

bind barometric_pressure_compensation bpc_checker u_bpc_checker (.*);
